### rtl/dnp_pkg.sv
// shared types, constants and digit accumulate functions for the decimal number text parser
package dnp_pkg;

	localparam int MANTISSA_BITS = 32;
	localparam int EXPONENT_BITS = 16;
	localparam int CHAR_BITS     = 8;
	localparam int COUNT_BITS    = 8;
	localparam int DIGIT_BITS    = 4;

	localparam int RESULT_BITS   = 1 + 32 + 32 + COUNT_BITS + 1 + 16 + 1 + CHAR_BITS;
	localparam int TDATA_BITS    = ((RESULT_BITS + 7) / 8) * 8;

	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_POINT = 8'h2e;
	localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_BITS-1:0] CH_UPPER_E = 8'h45;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_E = 8'h65;

	typedef enum logic [2:0] {
		PH_START     = 3'd0,
		PH_SIGN      = 3'd1,
		PH_INT       = 3'd2,
		PH_POINT     = 3'd3,
		PH_FRAC      = 3'd4,
		PH_EXP_MARK  = 3'd5,
		PH_EXP_SIGN  = 3'd6,
		PH_EXP       = 3'd7
	} phase_t;

	typedef struct packed {
		phase_t                   phase;
		logic                     negative;
		logic [MANTISSA_BITS-1:0] int_acc;
		logic [MANTISSA_BITS-1:0] frac_acc;
		logic [COUNT_BITS-1:0]    frac_cnt;
		logic                     exp_negative;
		logic [EXPONENT_BITS-1:0] exp_acc;
		logic                     overflow;
	} state_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0]  terminator;
		logic                  overflowed;
		logic [15:0]           exponent_magnitude;
		logic                  exponent_negative;
		logic [COUNT_BITS-1:0] fraction_count;
		logic [31:0]           fraction_value;
		logic [31:0]           integer_part;
		logic                  is_negative;
	} result_t;

	typedef struct packed {
		logic                     ovf;
		logic [MANTISSA_BITS-1:0] val;
	} mant_push_t;

	typedef struct packed {
		logic                     ovf;
		logic [EXPONENT_BITS-1:0] val;
	} exp_push_t;

	function automatic mant_push_t mant_push(input logic [MANTISSA_BITS-1:0] acc,
			input logic [DIGIT_BITS-1:0] d);
		logic [MANTISSA_BITS+3:0] wide;
		mant_push_t r;
		wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{MANTISSA_BITS{1'b0}}, d};
		r.ovf = |wide[MANTISSA_BITS+3:MANTISSA_BITS];
		r.val = r.ovf ? {MANTISSA_BITS{1'b1}} : wide[MANTISSA_BITS-1:0];
		return r;
	endfunction

	function automatic exp_push_t exp_push(input logic [EXPONENT_BITS-1:0] acc,
			input logic [DIGIT_BITS-1:0] d);
		logic [EXPONENT_BITS+3:0] wide;
		exp_push_t r;
		wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{EXPONENT_BITS{1'b0}}, d};
		r.ovf = |wide[EXPONENT_BITS+3:EXPONENT_BITS];
		r.val = r.ovf ? {EXPONENT_BITS{1'b1}} : wide[EXPONENT_BITS-1:0];
		return r;
	endfunction

	function automatic state_t cleared_state();
		state_t s;
		s.phase        = PH_START;
		s.negative     = 1'b0;
		s.int_acc      = '0;
		s.frac_acc     = '0;
		s.frac_cnt     = '0;
		s.exp_negative = 1'b0;
		s.exp_acc      = '0;
		s.overflow     = 1'b0;
		return s;
	endfunction

endpackage

### rtl/dnp_step.sv
// next parse state and result for one character
module dnp_step (
	input  dnp_pkg::state_t                  cur,
	input  logic [dnp_pkg::CHAR_BITS-1:0]    ch,
	input  logic                             eof,
	output dnp_pkg::state_t                  nxt,
	output logic                             done,
	output dnp_pkg::result_t                 res
);

	logic                              digit;
	logic [dnp_pkg::DIGIT_BITS-1:0]    d;
	logic                              is_sign;
	logic                              is_e;
	logic [dnp_pkg::CHAR_BITS-1:0]     ch_sub;
	dnp_pkg::mant_push_t               int_push;
	dnp_pkg::mant_push_t               frac_push;
	dnp_pkg::exp_push_t                ex_push;
	dnp_pkg::state_t                   upd;
	logic                              stop;

	assign digit   = (ch >= dnp_pkg::CH_ZERO) && (ch <= dnp_pkg::CH_NINE);
	assign ch_sub  = ch - dnp_pkg::CH_ZERO;
	assign d       = digit ? ch_sub[dnp_pkg::DIGIT_BITS-1:0] : '0;
	assign is_sign = (ch == dnp_pkg::CH_PLUS) || (ch == dnp_pkg::CH_MINUS);
	assign is_e    = (ch == dnp_pkg::CH_UPPER_E) || (ch == dnp_pkg::CH_LOWER_E);

	assign int_push  = dnp_pkg::mant_push(cur.int_acc, d);
	assign frac_push = dnp_pkg::mant_push(cur.frac_acc, d);
	assign ex_push   = dnp_pkg::exp_push(cur.exp_acc, d);

	always_comb begin
		upd  = cur;
		stop = 1'b0;
		unique case (cur.phase)
			dnp_pkg::PH_START: begin
				if (is_sign) begin
					upd.negative = (ch == dnp_pkg::CH_MINUS);
					upd.phase    = dnp_pkg::PH_SIGN;
				end else if (digit) begin
					upd.int_acc  = int_push.val;
					upd.overflow = cur.overflow | int_push.ovf;
					upd.phase    = dnp_pkg::PH_INT;
				end else if (ch == dnp_pkg::CH_POINT) begin
					upd.phase = dnp_pkg::PH_POINT;
				end else begin
					stop = 1'b1;
				end
			end
			dnp_pkg::PH_SIGN: begin
				if (ch == dnp_pkg::CH_POINT) begin
					upd.phase = dnp_pkg::PH_POINT;
				end else if (digit) begin
					upd.int_acc  = int_push.val;
					upd.overflow = cur.overflow | int_push.ovf;
					upd.phase    = dnp_pkg::PH_INT;
				end else begin
					stop = 1'b1;
				end
			end
			dnp_pkg::PH_INT: begin
				if (digit) begin
					upd.int_acc  = int_push.val;
					upd.overflow = cur.overflow | int_push.ovf;
				end else if (ch == dnp_pkg::CH_POINT) begin
					upd.phase = dnp_pkg::PH_FRAC;
				end else if (is_e) begin
					upd.phase = dnp_pkg::PH_EXP_MARK;
				end else begin
					stop = 1'b1;
				end
			end
			dnp_pkg::PH_POINT, dnp_pkg::PH_FRAC: begin
				if (digit) begin
					upd.frac_acc = frac_push.val;
					upd.frac_cnt = cur.frac_cnt + {{(dnp_pkg::COUNT_BITS-1){1'b0}},
						~(&cur.frac_cnt)};
					upd.overflow = cur.overflow | frac_push.ovf | (&cur.frac_cnt);
					upd.phase    = dnp_pkg::PH_FRAC;
				end else if (is_e && (cur.phase == dnp_pkg::PH_FRAC)) begin
					upd.phase = dnp_pkg::PH_EXP_MARK;
				end else begin
					stop = 1'b1;
				end
			end
			dnp_pkg::PH_EXP_MARK, dnp_pkg::PH_EXP_SIGN, dnp_pkg::PH_EXP: begin
				if (digit) begin
					upd.exp_acc  = ex_push.val;
					upd.overflow = cur.overflow | ex_push.ovf;
					upd.phase    = dnp_pkg::PH_EXP;
				end else if (is_sign && (cur.phase == dnp_pkg::PH_EXP_MARK)) begin
					upd.exp_negative = (ch == dnp_pkg::CH_MINUS);
					upd.phase        = dnp_pkg::PH_EXP_SIGN;
				end else begin
					stop = 1'b1;
				end
			end
		endcase
	end

	assign done = eof | stop;
	assign nxt  = done ? dnp_pkg::cleared_state() : upd;

	// result is the state before this character; an ending character never accumulates
	assign res.is_negative        = cur.negative;
	assign res.integer_part       = cur.int_acc;
	assign res.fraction_value     = cur.frac_acc;
	assign res.fraction_count     = cur.frac_cnt;
	assign res.exponent_negative  = cur.exp_negative;
	assign res.exponent_magnitude = cur.exp_acc;
	assign res.overflowed         = cur.overflow;
	assign res.terminator         = eof ? '0 : ch;

endmodule

### rtl/decimal_number_text_parser.sv
// top level of the decimal number text parser: input register, parse state, result register
// a character is taken into the input register, and the number it ends is loaded into the result register
// throughput: one character per cycle unless the result register stalls, set by the state update in dnp_step
// the input register stalls only while the result register holds an item not yet taken
// asynchronous active-low reset empties both registers and puts the parser in the start phase
module decimal_number_text_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // char_code[7:0]
	input  logic                             s_tlast,  // end_of_input
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dnp_pkg::TDATA_BITS-1:0]   m_tdata,  // is_negative, integer_part,
	                                                   // fraction_value, fraction_count,
	                                                   // exponent_negative, exponent_magnitude,
	                                                   // overflowed, terminator, zero fill
	output logic                             m_tlast   // ended_by_eof
);

	logic                           valid_s1;
	logic [dnp_pkg::CHAR_BITS-1:0]  char_s1;
	logic                           eof_s1;
	dnp_pkg::state_t                state_q;
	dnp_pkg::state_t                state_nxt;
	logic                           done;
	dnp_pkg::result_t               res;
	logic                           out_valid_q;
	dnp_pkg::result_t               out_res_q;
	logic                           out_eof_q;
	logic                           out_free;
	logic                           fire;

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	dnp_step u_step (
		.cur  (state_q),
		.ch   (char_s1),
		.eof  (eof_s1),
		.nxt  (state_nxt),
		.done (done),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dnp_pkg::cleared_state();
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && done;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && done) begin
			out_res_q <= res;
			out_eof_q <= eof_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(dnp_pkg::TDATA_BITS-dnp_pkg::RESULT_BITS){1'b0}}, out_res_q};
	assign m_tlast  = out_eof_q;

endmodule

### tb/decimal_number_text_parser_tb.sv
// self-checking testbench for decimal_number_text_parser: random character streams checked against a parse predictor
module decimal_number_text_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dnp_pkg::*;

	localparam int          ITEM_TARGET = 1725;
	localparam int          HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic       eoi;
		logic [7:0] ch;
	} char_item_t;

	typedef struct packed {
		logic        is_negative;
		logic [31:0] integer_part;
		logic [31:0] fraction_value;
		logic [7:0]  fraction_count;
		logic        exponent_negative;
		logic [15:0] exponent_magnitude;
		logic        overflowed;
		logic        ended_by_eof;
		logic [7:0]  terminator;
	} number_parts_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;
	logic                  m_tlast;

	char_item_t    pending_chars[$];
	number_parts_t expected_numbers[$];

	int          mismatches = 0;
	int          chars_accepted = 0;
	int          numbers_checked = 0;
	int          saturated_numbers = 0;
	int          eof_numbers = 0;
	int unsigned cycle_count = 0;
	logic        hold_off = 1'b0;

	phase_t                   num_phase = PH_START;
	logic                     num_negative = 1'b0;
	logic [MANTISSA_BITS-1:0] num_int = '0;
	logic [MANTISSA_BITS-1:0] num_frac = '0;
	logic [7:0]               num_frac_digits = '0;
	logic                     num_exp_negative = 1'b0;
	logic [EXPONENT_BITS-1:0] num_exp = '0;
	logic                     num_saturated = 1'b0;

	decimal_number_text_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] seen,
			input logic [63:0] want);
		if (seen !== want)
			flag_error($sformatf("number %0d: %s is %0h, expected %0h",
				numbers_checked, name, seen, want));
	endtask

	// accumulate one decimal digit, clamping at the all-ones value of the given width
	function automatic logic [64:0] shift_in_digit(input logic [63:0] acc,
			input logic [3:0] d, input int bits);
		logic [63:0] ceiling;
		logic [63:0] wide;
		ceiling = (64'd1 << bits) - 64'd1;
		wide = acc * 64'd10 + {60'd0, d};
		if (wide > ceiling)
			return {1'b1, ceiling};
		return {1'b0, wide};
	endfunction

	task automatic push_int(input logic [3:0] d);
		logic [64:0] step;
		step = shift_in_digit({{(64-MANTISSA_BITS){1'b0}}, num_int}, d, MANTISSA_BITS);
		num_saturated |= step[64];
		num_int = step[MANTISSA_BITS-1:0];
	endtask

	task automatic push_frac(input logic [3:0] d);
		logic [64:0] step;
		step = shift_in_digit({{(64-MANTISSA_BITS){1'b0}}, num_frac}, d, MANTISSA_BITS);
		num_saturated |= step[64];
		num_frac = step[MANTISSA_BITS-1:0];
		if (num_frac_digits == 8'hff)
			num_saturated = 1'b1;
		else
			num_frac_digits++;
	endtask

	task automatic push_exp(input logic [3:0] d);
		logic [64:0] step;
		step = shift_in_digit({{(64-EXPONENT_BITS){1'b0}}, num_exp}, d, EXPONENT_BITS);
		num_saturated |= step[64];
		num_exp = step[EXPONENT_BITS-1:0];
	endtask

	// advance the parse by one character and queue the parts when the number ends
	task automatic parse_char(input logic [7:0] ch, input logic eoi);
		logic          is_digit;
		logic          is_sign;
		logic          is_e;
		logic [3:0]    d;
		logic          ends;
		number_parts_t parts;
		is_digit = ch >= CH_ZERO && ch <= CH_NINE;
		is_sign = ch == CH_PLUS || ch == CH_MINUS;
		is_e = ch == CH_UPPER_E || ch == CH_LOWER_E;
		d = 4'(ch - CH_ZERO);
		ends = 1'b0;
		if (eoi) begin
			ends = 1'b1;
		end else begin
			case (num_phase)
				PH_START: begin
					if (is_sign) begin
						num_negative = ch == CH_MINUS;
						num_phase = PH_SIGN;
					end else if (is_digit) begin
						push_int(d);
						num_phase = PH_INT;
					end else if (ch == CH_POINT) begin
						num_phase = PH_POINT;
					end else begin
						ends = 1'b1;
					end
				end
				PH_SIGN: begin
					if (ch == CH_POINT) begin
						num_phase = PH_POINT;
					end else if (is_digit) begin
						push_int(d);
						num_phase = PH_INT;
					end else begin
						ends = 1'b1;
					end
				end
				PH_INT: begin
					if (is_digit) push_int(d);
					else if (ch == CH_POINT) num_phase = PH_FRAC;
					else if (is_e) num_phase = PH_EXP_MARK;
					else ends = 1'b1;
				end
				PH_POINT: begin
					if (is_digit) begin
						push_frac(d);
						num_phase = PH_FRAC;
					end else begin
						ends = 1'b1;
					end
				end
				PH_FRAC: begin
					if (is_digit) push_frac(d);
					else if (is_e) num_phase = PH_EXP_MARK;
					else ends = 1'b1;
				end
				PH_EXP_MARK: begin
					if (is_digit) begin
						push_exp(d);
						num_phase = PH_EXP;
					end else if (is_sign) begin
						num_exp_negative = ch == CH_MINUS;
						num_phase = PH_EXP_SIGN;
					end else begin
						ends = 1'b1;
					end
				end
				PH_EXP_SIGN: begin
					if (is_digit) begin
						push_exp(d);
						num_phase = PH_EXP;
					end else begin
						ends = 1'b1;
					end
				end
				default: begin
					if (is_digit) push_exp(d);
					else ends = 1'b1;
				end
			endcase
		end
		if (ends) begin
			parts.is_negative = num_negative;
			parts.integer_part = 32'(num_int);
			parts.fraction_value = 32'(num_frac);
			parts.fraction_count = num_frac_digits;
			parts.exponent_negative = num_exp_negative;
			parts.exponent_magnitude = 16'(num_exp);
			parts.overflowed = num_saturated;
			parts.ended_by_eof = eoi;
			parts.terminator = eoi ? 8'h00 : ch;
			expected_numbers.push_back(parts);
			num_phase = PH_START;
			num_negative = 1'b0;
			num_int = '0;
			num_frac = '0;
			num_frac_digits = '0;
			num_exp_negative = 1'b0;
			num_exp = '0;
			num_saturated = 1'b0;
		end
	endtask

	task automatic add_char(input logic [7:0] ch, input logic eoi);
		char_item_t item;
		item.ch = ch;
		item.eoi = eoi;
		pending_chars.push_back(item);
	endtask

	task automatic add_text(input string text);
		for (int i = 0; i < text.len(); i++)
			add_char(text[i], 1'b0);
	endtask

	task automatic add_digits(input int count);
		repeat (count) add_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
	endtask

	task automatic add_sign();
		int unsigned pick;
		pick = $urandom_range(0, 2);
		if (pick == 1) add_char(CH_PLUS, 1'b0);
		else if (pick == 2) add_char(CH_MINUS, 1'b0);
	endtask

	// mostly well-formed literals with random content, some noise and truncated forms
	task automatic add_number(input bit long_fraction);
		int unsigned pick;
		string       delims;
		delims = " ,;\n";
		pick = $urandom_range(0, 99);
		if (pick < 15 && !long_fraction) begin
			repeat ($urandom_range(1, 5))
				add_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			return;
		end
		add_sign();
		pick = $urandom_range(0, 99);
		if (pick < 10) ;
		else if (pick < 70) add_digits($urandom_range(1, 6));
		else if (pick < 90) add_digits($urandom_range(7, 11));
		else if (pick < 95) add_text("4294967295");
		else add_text("4294967296");
		if (long_fraction || $urandom_range(0, 9) < 6) begin
			add_char(CH_POINT, 1'b0);
			if (long_fraction) add_digits($urandom_range(256, 262));
			else if ($urandom_range(0, 99) < 15) add_digits($urandom_range(10, 12));
			else add_digits($urandom_range(0, 9));
		end
		if ($urandom_range(0, 9) < 4) begin
			add_char($urandom_range(0, 1) ? CH_UPPER_E : CH_LOWER_E, 1'b0);
			add_sign();
			pick = $urandom_range(0, 99);
			if (pick < 10) ;
			else if (pick < 75) add_digits($urandom_range(1, 4));
			else if (pick < 90) add_digits($urandom_range(5, 6));
			else if (pick < 95) add_text("65535");
			else add_text("65536");
		end
		pick = $urandom_range(0, 99);
		if (pick < 30) add_char(8'($urandom_range(0, 255)), 1'b1);
		else if (pick < 55) add_char(delims[$urandom_range(0, 3)], 1'b0);
		else add_char(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// sender
	int unsigned send_gap = 0;
	bit          send_burst = 0;

	always @(posedge clk) begin
		char_item_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap--;
			end else if (pending_chars.size() != 0) begin
				item = pending_chars.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= item.ch;
				s_tlast <= item.eoi;
				if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
				send_gap = send_burst ? 0 : $urandom_range(0, 7);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	int unsigned take_stall = 0;
	bit          take_burst = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if ($urandom_range(0, 40) == 0) take_burst = !take_burst;
				take_stall = take_burst ? 0 : $urandom_range(0, 7);
			end else if (take_stall != 0) begin
				take_stall--;
			end
			m_tready <= take_stall == 0 && !hold_off;
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	initial begin
		wait (chars_accepted >= 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// scoreboard
	always @(posedge clk) begin
		number_parts_t    want;
		dnp_pkg::result_t seen;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata[RESULT_BITS-1:0];
				if (expected_numbers.size() == 0) begin
					flag_error($sformatf("result with no number pending: %0h", m_tdata));
				end else begin
					want = expected_numbers.pop_front();
					check_field("is_negative", seen.is_negative, want.is_negative);
					check_field("integer_part", seen.integer_part, want.integer_part);
					check_field("fraction_value", seen.fraction_value, want.fraction_value);
					check_field("fraction_count", seen.fraction_count, want.fraction_count);
					check_field("exponent_negative", seen.exponent_negative,
						want.exponent_negative);
					check_field("exponent_magnitude", seen.exponent_magnitude,
						want.exponent_magnitude);
					check_field("overflowed", seen.overflowed, want.overflowed);
					check_field("ended_by_eof", m_tlast, want.ended_by_eof);
					check_field("terminator", seen.terminator, want.terminator);
					check_field("zero fill", m_tdata[TDATA_BITS-1:RESULT_BITS], 0);
					if (want.overflowed) saturated_numbers++;
					if (want.ended_by_eof) eof_numbers++;
					numbers_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				chars_accepted++;
				parse_char(s_tdata, s_tlast);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("decimal_number_text_parser regression: fail");
		$finish;
	end

	initial begin
		int numbers_made;
		int long_at;
		// directed: empty input, odd terminators, every sign and marker
		add_char(8'ha5, 1'b1);
		add_char(8'hff, 1'b0);
		add_text("-1.5E+9;");
		add_text("+.25e-7");
		add_char(8'h5a, 1'b1);
		add_text("9.");
		add_char(8'h00, 1'b0);
		add_text("0");
		add_char(8'h80, 1'b0);
		add_text("-x");
		numbers_made = 0;
		long_at = $urandom_range(10, 60);
		while (pending_chars.size() < ITEM_TARGET) begin
			add_number(numbers_made == long_at || $urandom_range(0, 149) == 0);
			numbers_made++;
		end
		add_char(8'h00, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_numbers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d characters parsed into %0d numbers", chars_accepted, numbers_checked);
		$display("%0d numbers saturated, %0d ended by end of input",
			saturated_numbers, eof_numbers);
		if (mismatches == 0)
			$display("decimal_number_text_parser regression: pass");
		else
			$display("decimal_number_text_parser regression: fail");
		$finish;
	end

endmodule
